// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/sts_pkg.sv -----
// Types and constants of the sorted time schedule table.
`default_nettype none

package sts_pkg;

    // Default capacity of the record store
    localparam int STS_MAX_RECORDS = 16;

    // Width of the reported record count
    localparam int STS_CNT_W = 5;

    // Item modes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_DEL   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // One input beat
    typedef struct packed {
        logic [1:0]         mode;
        logic [10:0]        time_key;
        logic               new_state;
        logic signed [7:0]  new_temp;
        logic [7:0]         new_humid;
    } t_in_item;

    // One result beat
    typedef struct packed {
        logic [1:0]         status;
        logic               active_state;
        logic signed [7:0]  active_temp;
        logic [7:0]         active_humid;
        logic [STS_CNT_W-1:0] record_count;
    } t_out_item;

    // One stored schedule record
    typedef struct packed {
        logic [10:0]        key;
        logic               state;
        logic signed [7:0]  temp;
        logic [7:0]         humid;
    } t_rec;

    localparam int STS_REC_W = $bits(t_rec);

endpackage

`default_nettype wire

// ----- sv/sts_stream_if.sv -----
// Valid/ready stream interface carrying one payload beat.
`default_nettype none

interface sts_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/sts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- sv/sts_seq.sv -----
// Sequencer: scans the record store, then for an edit shifts and writes records back.
`default_nettype none

module sts_seq #(
    parameter int MAX_RECORDS = 16,
    parameter int AW          = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_item_valid,
    output logic                   o_item_ready,
    input  wire sts_pkg::t_in_item i_item,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output sts_pkg::t_out_item     o_res,
    output logic                   o_rd_en,
    output logic [AW-1:0]          o_rd_addr,
    input  wire sts_pkg::t_rec     i_rd_data,
    output logic                   o_wr_en,
    output logic [AW-1:0]          o_wr_addr,
    output sts_pkg::t_rec          o_wr_data
);
    import sts_pkg::*;

    localparam int CW = $clog2(MAX_RECORDS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MOVE  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [CW-1:0] r_total;
    logic          r_rd_vld;
    logic          r_mv_vld;

    t_in_item      r_item;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_lt_cnt;
    logic          r_eq;
    t_rec          r_cap;
    logic          r_cap_vld;
    t_rec          r_last;
    logic [CW-1:0] r_src;
    logic [CW-1:0] r_left;
    logic          r_up;
    logic [CW-1:0] r_mv_dst;
    logic [1:0]    r_status;

    logic scan_issue;
    logic scan_end;
    logic is_full;
    logic do_insert;
    logic do_remove;
    logic move_end;
    t_rec new_rec;
    t_rec act_rec;

    assign scan_issue = (r_state == S_SCAN) && (r_idx != r_total);
    assign scan_end   = (r_state == S_SCAN) && (r_idx == r_total) && !r_rd_vld;
    assign is_full    = (r_total == CW'(MAX_RECORDS));
    assign do_insert  = scan_end && (r_item.mode == MODE_ADD) && !r_eq && !is_full;
    assign do_remove  = scan_end && (r_item.mode == MODE_DEL) && r_eq;
    assign move_end   = (r_state == S_MOVE) && (r_left == '0) && !r_mv_vld;

    assign new_rec.key   = r_item.time_key;
    assign new_rec.state = r_item.new_state;
    assign new_rec.temp  = r_item.new_temp;
    assign new_rec.humid = r_item.new_humid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    unique case (r_item.mode)
                        MODE_ADD: begin
                            if (r_eq) begin
                                n_state = S_WRITE;
                            end else if (is_full) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_MOVE;
                            end
                        end
                        MODE_DEL: begin
                            n_state = r_eq ? S_MOVE : S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MOVE: begin
                if (move_end) begin
                    n_state = r_up ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_rd_vld <= 1'b0;
            r_mv_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= scan_issue;
            r_mv_vld <= (r_state == S_MOVE) && (r_left != '0);
            if (do_insert) begin
                r_total <= r_total + CW'(1);
            end else if (do_remove) begin
                r_total <= r_total - CW'(1);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Latch a new beat and clear the scan results
        if ((r_state == S_IDLE) && i_item_valid) begin
            r_item    <= i_item;
            r_idx     <= '0;
            r_lt_cnt  <= '0;
            r_eq      <= 1'b0;
            r_cap     <= '0;
            r_cap_vld <= 1'b0;
            r_last    <= '0;
            r_status  <= ST_OK;
        end

        // Advance the scan and fold in each returned record
        if (scan_issue) begin
            r_idx <= r_idx + CW'(1);
        end
        if ((r_state == S_SCAN) && r_rd_vld) begin
            r_last <= i_rd_data;
            if (i_rd_data.key < r_item.time_key) begin
                r_lt_cnt <= r_lt_cnt + CW'(1);
            end
            if (i_rd_data.key == r_item.time_key) begin
                r_eq <= 1'b1;
            end
            if (i_rd_data.key <= r_item.time_key) begin
                r_cap     <= i_rd_data;
                r_cap_vld <= 1'b1;
            end
        end

        // Set up the shift or flag the refusal
        if (scan_end) begin
            if (do_insert) begin
                r_src  <= r_total - CW'(1);
                r_left <= r_total - r_lt_cnt;
                r_up   <= 1'b1;
            end else if (do_remove) begin
                r_src  <= r_lt_cnt + CW'(1);
                r_left <= r_total - r_lt_cnt - CW'(1);
                r_up   <= 1'b0;
            end
            if ((r_item.mode == MODE_ADD) && !r_eq && is_full) begin
                r_status <= ST_FULL;
            end
            if ((r_item.mode == MODE_DEL) && !r_eq) begin
                r_status <= ST_NOTFOUND;
            end
        end

        // Step the shift, one record read per cycle
        if ((r_state == S_MOVE) && (r_left != '0)) begin
            r_left   <= r_left - CW'(1);
            r_src    <= r_up ? (r_src - CW'(1)) : (r_src + CW'(1));
            r_mv_dst <= r_up ? (r_src + CW'(1)) : (r_src - CW'(1));
        end
    end

    // Memory port drive
    assign o_rd_en   = scan_issue || ((r_state == S_MOVE) && (r_left != '0));
    assign o_rd_addr = (r_state == S_MOVE) ? r_src[AW-1:0] : r_idx[AW-1:0];
    assign o_wr_en   = ((r_state == S_MOVE) && r_mv_vld) || (r_state == S_WRITE);
    assign o_wr_addr = (r_state == S_MOVE) ? r_mv_dst[AW-1:0] : r_lt_cnt[AW-1:0];
    assign o_wr_data = (r_state == S_MOVE) ? i_rd_data : new_rec;

    // Result beat: wrap to the last record when no key is at or before the query
    assign act_rec = r_cap_vld ? r_cap : r_last;

    always_comb begin
        o_res              = '0;
        o_res.status       = r_status;
        o_res.record_count = STS_CNT_W'(r_total);
        if (r_item.mode == MODE_QUERY) begin
            o_res.active_state = act_rec.state;
            o_res.active_temp  = act_rec.temp;
            o_res.active_humid = act_rec.humid;
        end
    end

    assign o_res_valid  = (r_state == S_DONE);
    assign o_item_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ----- sv/sorted_time_schedule_table.sv -----
// Top level of the sorted time schedule table.
//
// Keeps up to MAX_RECORDS schedule records sorted by a minutes-since-midnight
// key. Input beats on i_in carry a mode (add/update, delete, query), a key and
// the record fields for an add. Every input beat gives exactly one result beat
// on o_out: a status, the active record fields for a query and the record
// count after the item.
// One item is handled at a time. The pace is set by the single read port of the
// record memory: the scan reads one record a cycle, and the shift moves one
// record a cycle. The result sits in an output register, so the next beat is
// accepted while a result waits; a stalled receiver holds that result and the
// next item stops in its final state until the register frees.
// Reset clears the record count and the control state; the record memory is
// not cleared, as entries past the count are never read.
`default_nettype none

module sorted_time_schedule_table #(
    parameter int MAX_RECORDS = sts_pkg::STS_MAX_RECORDS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sts_stream_if.sink   i_in,
    sts_stream_if.source o_out
);
    import sts_pkg::*;

    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

    logic                 res_valid;
    logic                 res_ready;
    t_out_item            res;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [STS_REC_W-1:0] rd_raw;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    t_rec                 wr_data;
    logic                 r_out_vld;
    t_out_item            r_out;

    sts_seq #(
        .MAX_RECORDS (MAX_RECORDS),
        .AW          (AW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_in.valid),
        .o_item_ready (i_in.ready),
        .i_item       (i_in.data),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (t_rec'(rd_raw)),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    sts_ram #(
        .WIDTH (STS_REC_W),
        .DEPTH (MAX_RECORDS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Output register: take a result when empty or being drained
    assign res_ready = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

// ----- sv/sts_checker.sv -----
// Port-level checker of the sorted time schedule table and its bind.
`default_nettype none
`include "assert_macros.svh"

module sts_checker #(
    parameter int MAX_RECORDS = sts_pkg::STS_MAX_RECORDS
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire sts_pkg::t_out_item i_out_data
);
    import sts_pkg::*;

    // Count never runs past the capacity
    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, i_out_valid |-> (32'(i_out_data.record_count) <= 32'(MAX_RECORDS)), "record count above capacity")

    // A full refusal only happens with the table at capacity
    `ASSERT_CLK(a_full_count, i_clk, i_rst_n, (i_out_valid && (i_out_data.status == ST_FULL)) |-> (i_out_data.record_count == STS_CNT_W'(MAX_RECORDS)), "full status below capacity")

    // Refused edits carry no active record
    `ASSERT_CLK(a_err_quiet, i_clk, i_rst_n, (i_out_valid && (i_out_data.status != ST_OK)) |-> (!i_out_data.active_state && (i_out_data.active_temp == '0) && (i_out_data.active_humid == '0)), "active fields set on an error beat")

    // Hold a stalled result beat
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)), "result beat dropped or changed under stall")

    // Come out of reset empty and ready
    `ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> (!i_out_valid && i_in_ready), "not idle after reset")

endmodule

bind sorted_time_schedule_table sts_checker #(
    .MAX_RECORDS (MAX_RECORDS)
) u_sts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire
